// ----- rtl/bmo_pkg.sv -----
// shared types, constants and helper functions for the bicycle odometry block
package bmo_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_YAWP,
    S_YAWD,
    S_CSA,
    S_CSB,
    S_MX1,
    S_MX2,
    S_MY1,
    S_MY2,
    S_DX,
    S_DY,
    S_VX,
    S_VY,
    S_CSS,
    S_NUM,
    S_DEN,
    S_RDIV,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_CSQ,
    S_OUT
  } state_t;

  localparam logic [2:0] CFG_WHEELBASE = 3'd0;
  localparam logic [2:0] CFG_STEP_TIME = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_INIT_X    = 3'd3;
  localparam logic [2:0] CFG_INIT_Y    = 3'd4;

  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [31:0]        YAW_STEP_K  = 32'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  localparam int unsigned MUL_STEPS    = 32;
  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned DIV_STEPS    = 96;
  localparam int unsigned SQRT_STEPS   = 32;

  function automatic logic [29:0] atan_at(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10680862;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // round half away from zero, then shift right by s
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? -v : v;
    r = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -r : r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/bmo_mul.sv -----
// shift-add multiplier, one multiplier bit per cycle, 64-bit wrapped product
module bmo_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  input  logic        b_signed,
  output logic        done,
  output logic [63:0] prod
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] areg;
  logic [31:0] breg;
  logic [63:0] acc;
  logic        neg;

  assign prod = neg ? -acc : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(bmo_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= (b_signed && b[31]) ? -b : b;
      neg  <= b_signed && b[31];
      acc  <= '0;
    end else if (busy) begin
      if (breg[0]) begin
        acc <= acc + areg;
      end
      areg <= {areg[62:0], 1'b0};
      breg <= {1'b0, breg[31:1]};
    end
  end

endmodule

// ----- rtl/bmo_cordic.sv -----
// iterative rotation cordic giving cos and sin in q2.30, one step per cycle
module bmo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  logic               busy;
  logic [4:0]         it;
  logic               flip;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic [1:0]         quad;
  logic [31:0]        ang_rot;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  function automatic logic signed [31:0] sat30(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > bmo_pkg::ONE_Q30) begin
      r = bmo_pkg::ONE_Q30;
    end else if (v < -bmo_pkg::ONE_Q30) begin
      r = -bmo_pkg::ONE_Q30;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

  always_comb begin
    quad    = angle[31:30];
    ang_rot = (quad == 2'd1 || quad == 2'd2) ? angle + 32'h8000_0000 : angle;
    xs      = x >>> it;
    ys      = y >>> it;
    at      = {4'b0, bmo_pkg::atan_at(it)};
    xf      = flip ? -x : x;
    yf      = flip ? -y : y;
  end

  assign cos_q = sat30(xf);
  assign sin_q = sat30(yf);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        it   <= '0;
      end else if (busy) begin
        it <= it + 5'd1;
        if (it == 5'(bmo_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= (quad == 2'd1 || quad == 2'd2);
      x    <= bmo_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= {{2{ang_rot[31]}}, ang_rot};
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

// ----- rtl/bmo_div.sv -----
// restoring divider, one quotient bit per cycle, with quotient overflow flag
module bmo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo,
  output logic        ovf
);

  logic        busy;
  logic [6:0]  cnt;
  logic [95:0] dvd;
  logic [63:0] dreg;
  logic [63:0] rem;
  logic [64:0] r2;
  logic        fits;

  always_comb begin
    r2   = {rem, dvd[95]};
    fits = (r2 >= {1'b0, dreg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(bmo_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= num;
      dreg <= den;
      rem  <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[94:0], 1'b0};
      rem <= fits ? 64'(r2 - {1'b0, dreg}) : r2[63:0];
      quo <= {quo[62:0], fits};
      ovf <= ovf | quo[63];
    end
  end

endmodule

// ----- rtl/bmo_sqrt.sv -----
// digit-by-digit integer square root, two radicand bits per cycle
module bmo_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitm;
  logic [63:0] t;

  assign t    = r + bitm;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(bmo_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= val;
      r    <= '0;
      bitm <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= t) begin
        v <= v - t;
        r <= {1'b0, r[63:1]} + bitm;
      end else begin
        r <= {1'b0, r[63:1]};
      end
      bitm <= {2'b00, bitm[63:2]};
    end
  end

endmodule

// ----- rtl/bicycle_model_odometry_step_top.sv -----
// bicycle odometry step: sequencer with serial multiplier, cordic, divider and square root
// sequencing: a command is taken while idle; a tick before the first command goes
//   straight to the output state, a later tick runs the straight or arc sequence
//   through the 32-step multiplier, 31-step cordic, 96-step divider and square root
// throughput: one tick at a time; the next transaction is taken once the result is stored
// reset: clears all motion state and loads the register defaults
module bicycle_model_odometry_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] cmd_speed_in,
  input  logic signed [15:0] cmd_steer_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic [14:0]        quat_w,
  output logic signed [15:0] quat_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] turn_rate
);

  bmo_pkg::state_t state;
  bmo_pkg::state_t state_next;
  logic            issued;
  logic            issued_next;

  // configuration
  logic [30:0]        wheelbase;
  logic [15:0]        step_time;
  logic [15:0]        threshold;
  logic signed [31:0] init_x;
  logic signed [31:0] init_y;

  // motion state
  logic               cmd_seen;
  logic signed [31:0] held_speed;
  logic signed [15:0] held_steer;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic [15:0]        cur_yaw;
  logic [31:0]        speed_mag;
  logic signed [31:0] cur_yaw_rate;

  // working registers
  logic signed [63:0] tmp;
  logic signed [63:0] den_r;
  logic [31:0]        b_ang;
  logic signed [31:0] ca;
  logic signed [31:0] sa;
  logic signed [31:0] cb;
  logic signed [31:0] sb;
  logic signed [63:0] nx;
  logic signed [63:0] ny;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] rate;
  logic [15:0]        yaw_new;
  logic [31:0]        mag_new;
  logic [14:0]        qw;
  logic signed [15:0] qz;

  // unit control
  logic        mul_start;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_bs;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic        cor_start;
  logic [31:0] cor_ang;
  logic        cor_done;
  logic signed [31:0] cor_cos;
  logic signed [31:0] cor_sin;
  logic        div_start;
  logic [95:0] div_num;
  logic [63:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;
  logic        div_ovf;
  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;
  logic        cap;
  logic        out_load;
  logic        in_acc;

  // derived values
  logic signed [63:0] w64;
  logic [63:0]        w_abs;
  logic               straight;
  logic [63:0]        ud_arc;
  logic [63:0]        tmp_abs;
  logic [63:0]        den_abs;
  logic [63:0]        d_round;
  logic [31:0]        b_round;
  logic               q_neg;
  logic [63:0]        q_signed;
  logic               r_neg;
  logic               r_big;
  logic [33:0]        r_inc;
  logic [32:0]        r_half;
  logic [32:0]        r_lim;
  logic [32:0]        r_mag;
  logic signed [63:0] qc64;
  logic signed [63:0] qs64;

  assign in_stall = (state != bmo_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cap      = issued && (mul_done || cor_done || div_done || sq_done);

  always_comb begin
    w64      = bmo_pkg::sx32(cur_yaw_rate);
    w_abs    = cur_yaw_rate[31] ? -w64 : w64;
    straight = (w_abs < {48'h0, threshold}) || (cur_yaw_rate == 32'sd0);
    ud_arc   = {w_abs[49:0], 14'h0};
    tmp_abs  = tmp[63] ? -tmp : tmp;
    den_abs  = den_r[63] ? -den_r : den_r;
    d_round  = mul_prod + 64'h0000_0000_8000_0000;
    b_round  = b_ang + 32'h0000_8000;
    q_neg    = tmp[63] ^ cur_yaw_rate[31];
    q_signed = q_neg ? -div_quo : div_quo;
    r_neg    = tmp[63] ^ den_r[63];
    r_big    = div_ovf || (div_quo[63:33] != 31'h0);
    r_inc    = {1'b0, div_quo[32:0]} + 34'd1;
    r_half   = r_inc[33:1];
    r_lim    = r_neg ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
    r_mag    = (r_big || r_half > r_lim) ? r_lim : r_half;
    qc64     = bmo_pkg::rnd_sh(bmo_pkg::sx32(cor_cos), 15);
    qs64     = bmo_pkg::rnd_sh(bmo_pkg::sx32(cor_sin), 15);
  end

  bmo_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .a        (mul_a),
    .b        (mul_b),
    .b_signed (mul_bs),
    .done     (mul_done),
    .prod     (mul_prod)
  );

  bmo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_ang),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  bmo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  bmo_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (tmp),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bmo_pkg::S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_bs     = 1'b0;
    cor_start  = 1'b0;
    cor_ang    = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sq_start   = 1'b0;
    out_load   = 1'b0;
    case (state)
      bmo_pkg::S_IDLE: begin
        if (in_acc && func == bmo_pkg::FUNC_TICK) begin
          state_next = cmd_seen ? bmo_pkg::S_YAWP : bmo_pkg::S_OUT;
        end
      end
      bmo_pkg::S_YAWP: begin
        mul_a     = w64;
        mul_b     = {16'h0, step_time};
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_YAWD;
      end
      bmo_pkg::S_YAWD: begin
        mul_a     = tmp;
        mul_b     = bmo_pkg::YAW_STEP_K;
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_CSA;
      end
      bmo_pkg::S_CSA: begin
        cor_ang   = {cur_yaw, 16'h0};
        cor_start = !issued;
        if (cap) state_next = straight ? bmo_pkg::S_MX1 : bmo_pkg::S_CSB;
      end
      bmo_pkg::S_CSB: begin
        cor_ang   = b_ang;
        cor_start = !issued;
        if (cap) state_next = bmo_pkg::S_MX1;
      end
      bmo_pkg::S_MX1: begin
        mul_a     = straight ? bmo_pkg::sx32(ca) : bmo_pkg::sx32(sb) - bmo_pkg::sx32(sa);
        mul_b     = speed_mag;
        mul_start = !issued;
        if (cap) state_next = straight ? bmo_pkg::S_MX2 : bmo_pkg::S_DX;
      end
      bmo_pkg::S_MX2: begin
        mul_a     = bmo_pkg::rnd_sh(tmp, 30);
        mul_b     = {16'h0, step_time};
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_MY1;
      end
      bmo_pkg::S_MY1: begin
        mul_a     = straight ? bmo_pkg::sx32(sa) : bmo_pkg::sx32(ca) - bmo_pkg::sx32(cb);
        mul_b     = speed_mag;
        mul_start = !issued;
        if (cap) state_next = straight ? bmo_pkg::S_MY2 : bmo_pkg::S_DY;
      end
      bmo_pkg::S_MY2: begin
        mul_a     = bmo_pkg::rnd_sh(tmp, 30);
        mul_b     = {16'h0, step_time};
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_VX;
      end
      bmo_pkg::S_DX: begin
        div_num   = {32'h0, tmp_abs + {1'b0, ud_arc[63:1]}};
        div_den   = ud_arc;
        div_start = !issued;
        if (cap) state_next = bmo_pkg::S_MY1;
      end
      bmo_pkg::S_DY: begin
        div_num   = {32'h0, tmp_abs + {1'b0, ud_arc[63:1]}};
        div_den   = ud_arc;
        div_start = !issued;
        if (cap) state_next = bmo_pkg::S_VX;
      end
      bmo_pkg::S_VX: begin
        mul_a     = bmo_pkg::sx32(ca);
        mul_b     = held_speed;
        mul_bs    = 1'b1;
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_VY;
      end
      bmo_pkg::S_VY: begin
        mul_a     = bmo_pkg::sx32(sa);
        mul_b     = held_speed;
        mul_bs    = 1'b1;
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_CSS;
      end
      bmo_pkg::S_CSS: begin
        cor_ang   = {held_steer, 16'h0};
        cor_start = !issued;
        if (cap) state_next = bmo_pkg::S_NUM;
      end
      bmo_pkg::S_NUM: begin
        mul_a     = bmo_pkg::sx32(sb);
        mul_b     = held_speed;
        mul_bs    = 1'b1;
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_DEN;
      end
      bmo_pkg::S_DEN: begin
        mul_a     = bmo_pkg::sx32(cb);
        mul_b     = {1'b0, wheelbase};
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_RDIV;
      end
      bmo_pkg::S_RDIV: begin
        div_num = {15'h0, tmp_abs, 17'h0};
        div_den = den_abs;
        if (!issued && (tmp == 64'sd0 || den_r == 64'sd0)) begin
          state_next = bmo_pkg::S_SQX;
        end else begin
          div_start = !issued;
          if (cap) state_next = bmo_pkg::S_SQX;
        end
      end
      bmo_pkg::S_SQX: begin
        mul_a     = bmo_pkg::sx32(vx);
        mul_b     = vx;
        mul_bs    = 1'b1;
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_SQY;
      end
      bmo_pkg::S_SQY: begin
        mul_a     = bmo_pkg::sx32(vy);
        mul_b     = vy;
        mul_bs    = 1'b1;
        mul_start = !issued;
        if (cap) state_next = bmo_pkg::S_SQRT;
      end
      bmo_pkg::S_SQRT: begin
        sq_start = !issued;
        if (cap) state_next = bmo_pkg::S_CSQ;
      end
      bmo_pkg::S_CSQ: begin
        cor_ang   = {yaw_new[15], yaw_new, 15'h0};
        cor_start = !issued;
        if (cap) state_next = bmo_pkg::S_OUT;
      end
      bmo_pkg::S_OUT: begin
        out_load = !out_valid || !out_stall;
        if (out_load) state_next = bmo_pkg::S_IDLE;
      end
      default: begin
        state_next = bmo_pkg::S_IDLE;
      end
    endcase
    issued_next = issued;
    if (mul_start || cor_start || div_start || sq_start) issued_next = 1'b1;
    if (cap) issued_next = 1'b0;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == bmo_pkg::S_IDLE && in_acc && func == bmo_pkg::FUNC_TICK && !cmd_seen) begin
      nx      <= bmo_pkg::sx32(init_x);
      ny      <= bmo_pkg::sx32(init_y);
      yaw_new <= '0;
      qw      <= 15'h7fff;
      qz      <= '0;
      vx      <= '0;
      vy      <= '0;
      rate    <= '0;
      mag_new <= '0;
    end
    if (state == bmo_pkg::S_RDIV && !issued) begin
      if (tmp == 64'sd0) begin
        rate <= '0;
      end else if (den_r == 64'sd0) begin
        rate <= tmp[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
    end
    if (cap) begin
      case (state)
        bmo_pkg::S_YAWP: tmp <= mul_prod;
        bmo_pkg::S_YAWD: b_ang <= {cur_yaw, 16'h0} + d_round[63:32];
        bmo_pkg::S_CSA: begin
          ca      <= cor_cos;
          sa      <= cor_sin;
          yaw_new <= straight ? cur_yaw : b_round[31:16];
        end
        bmo_pkg::S_CSB: begin
          cb <= cor_cos;
          sb <= cor_sin;
        end
        bmo_pkg::S_MX1: tmp <= mul_prod;
        bmo_pkg::S_MX2: nx <= bmo_pkg::sx32(cur_x) + bmo_pkg::rnd_sh(mul_prod, 16);
        bmo_pkg::S_MY1: tmp <= mul_prod;
        bmo_pkg::S_MY2: ny <= bmo_pkg::sx32(cur_y) + bmo_pkg::rnd_sh(mul_prod, 16);
        bmo_pkg::S_DX: nx <= bmo_pkg::sx32(cur_x) + q_signed;
        bmo_pkg::S_DY: ny <= bmo_pkg::sx32(cur_y) + q_signed;
        bmo_pkg::S_VX: vx <= bmo_pkg::clamp32(bmo_pkg::rnd_sh(mul_prod, 30));
        bmo_pkg::S_VY: vy <= bmo_pkg::clamp32(bmo_pkg::rnd_sh(mul_prod, 30));
        bmo_pkg::S_CSS: begin
          cb <= cor_cos;
          sb <= cor_sin;
        end
        bmo_pkg::S_NUM: tmp <= mul_prod;
        bmo_pkg::S_DEN: den_r <= mul_prod;
        bmo_pkg::S_RDIV: rate <= r_neg ? -r_mag[31:0] : r_mag[31:0];
        bmo_pkg::S_SQX: tmp <= mul_prod;
        bmo_pkg::S_SQY: tmp <= tmp + mul_prod;
        bmo_pkg::S_SQRT: mag_new <= sq_root;
        bmo_pkg::S_CSQ: begin
          if (qc64 < 64'sd0) begin
            qw <= '0;
          end else if (qc64 > 64'sd32767) begin
            qw <= 15'h7fff;
          end else begin
            qw <= qc64[14:0];
          end
          if (qs64 > 64'sd32767) begin
            qz <= 16'sh7fff;
          end else if (qs64 < -64'sd32768) begin
            qz <= 16'sh8000;
          end else begin
            qz <= qs64[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration and motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase    <= 31'd65536;
      step_time    <= 16'd655;
      threshold    <= 16'd7;
      init_x       <= '0;
      init_y       <= '0;
      cmd_seen     <= 1'b0;
      held_speed   <= '0;
      held_steer   <= '0;
      cur_x        <= '0;
      cur_y        <= '0;
      cur_yaw      <= '0;
      speed_mag    <= '0;
      cur_yaw_rate <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bmo_pkg::CFG_WHEELBASE: wheelbase <= cfg_data[30:0];
          bmo_pkg::CFG_STEP_TIME: step_time <= cfg_data[15:0];
          bmo_pkg::CFG_THRESHOLD: threshold <= cfg_data[15:0];
          bmo_pkg::CFG_INIT_X:    init_x    <= cfg_data;
          bmo_pkg::CFG_INIT_Y:    init_y    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_acc && func == bmo_pkg::FUNC_CMD) begin
        held_speed <= cmd_speed_in;
        held_steer <= cmd_steer_in;
        cmd_seen   <= 1'b1;
        if (!cmd_seen) begin
          cur_x <= init_x;
          cur_y <= init_y;
        end
      end
      if (out_load) begin
        cur_x        <= bmo_pkg::clamp32(nx);
        cur_y        <= bmo_pkg::clamp32(ny);
        cur_yaw      <= yaw_new;
        speed_mag    <= mag_new;
        cur_yaw_rate <= rate;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x     <= bmo_pkg::clamp32(nx);
      pos_y     <= bmo_pkg::clamp32(ny);
      heading   <= yaw_new;
      quat_w    <= qw;
      quat_z    <= qz;
      vel_x     <= vx;
      vel_y     <= vy;
      turn_rate <= rate;
    end
  end

endmodule

// ----- test/bicycle_model_odometry_step_top_tb.sv -----
// testbench for the bicycle odometry step block: bit-exact pose prediction and scoreboard
module bicycle_model_odometry_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [14:0]        quat_w;
    logic signed [15:0] quat_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
  } pose_t;

  class pose_scoreboard;
    pose_t       pose_q[$];
    int          errors;
    logic [30:0] wheelbase;
    logic [15:0] step_time;
    logic [15:0] threshold;
    logic signed [31:0] init_x, init_y;
    bit          cmd_seen;
    logic signed [31:0] held_speed;
    logic signed [15:0] held_steer;
    logic signed [31:0] cur_x, cur_y;
    logic [15:0] cur_yaw;
    logic [31:0] speed_mag;
    logic signed [31:0] cur_rate;
    longint      atan_k[31] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

    function new();
      errors = 0;
      wheelbase = 65536; step_time = 655; threshold = 7; init_x = 0; init_y = 0;
      cmd_seen = 0; held_speed = 0; held_steer = 0; cur_x = 0; cur_y = 0;
      cur_yaw = 0; speed_mag = 0; cur_rate = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        bmo_pkg::CFG_WHEELBASE: wheelbase = v[30:0];
        bmo_pkg::CFG_STEP_TIME: step_time = v[15:0];
        bmo_pkg::CFG_THRESHOLD: threshold = v[15:0];
        bmo_pkg::CFG_INIT_X:    init_x = v;
        bmo_pkg::CFG_INIT_Y:    init_y = v;
        default: ;
      endcase
    endfunction

    function longint rnd(longint v, int s);
      longint h;
      h = longint'(1) <<< (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -(((-v) + h) >>> s);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint div_round(longint num, longint den);
      logic [63:0] un, ud, q;
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      q = (un + ud / 2) / ud;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    task automatic sincos(input logic [31:0] ang, output longint c, output longint s);
      bit neg;
      longint x, y, z, t;
      neg = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (neg) ang = ang + 32'h8000_0000;
      z = longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 31; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - atan_k[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + atan_k[i];
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      c = clip(x, -64'sd1073741824, 64'sd1073741824);
      s = clip(y, -64'sd1073741824, 64'sd1073741824);
    endtask

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b); r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    task automatic turn_rate_of(input longint v, input logic [15:0] steer, output longint rate);
      longint c, s, num, den;
      logic [63:0] un, ud, qi, r, m, lim;
      bit neg;
      sincos({steer, 16'h0}, c, s);
      num = v * s;
      den = c * longint'(wheelbase);
      neg = (num < 0) != (den < 0);
      if (num == 0) rate = 0;
      else if (den == 0) rate = num < 0 ? -64'sd2147483648 : 64'sd2147483647;
      else begin
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        qi = un / ud;
        r = un % ud;
        if (qi >= 65536) m = lim;
        else begin
          m = qi;
          for (int i = 0; i < 17; i++) begin
            m = m << 1; r = r << 1;
            if (r >= ud) begin
              r = r - ud; m = m | 1;
            end
          end
          m = (m + 1) >> 1;
          if (m > lim) m = lim;
        end
        rate = neg ? -longint'(m) : longint'(m);
      end
    endtask

    task automatic note(input logic f, input logic signed [31:0] spd,
                        input logic signed [15:0] str);
      pose_t e;
      longint w, ca, sa, cb, sb, qc, qs, nx, ny, vx, vy, rate, p, aw;
      logic [31:0] a, b, d, yq;
      logic [63:0] pk;
      logic [15:0] yaw;
      if (f == bmo_pkg::FUNC_CMD) begin
        held_speed = spd;
        held_steer = str;
        if (!cmd_seen) begin
          cur_x = init_x; cur_y = init_y;
        end
        cmd_seen = 1;
        return;
      end
      if (!cmd_seen) begin
        e = '{init_x, init_y, 16'sd0, 15'd32767, 16'sd0, 32'sd0, 32'sd0, 32'sd0};
        pose_q.push_back(e);
        return;
      end
      w = cur_rate;
      a = {cur_yaw, 16'h0};
      p = w * longint'(step_time);
      pk = 64'(p) * 64'd683565276 + 64'h8000_0000;
      d = pk[63:32];
      b = a + d;
      sincos(a, ca, sa);
      aw = w < 0 ? -w : w;
      if (aw < longint'(threshold) || w == 0) begin
        nx = cur_x + rnd(rnd(longint'(speed_mag) * ca, 30) * longint'(step_time), 16);
        ny = cur_y + rnd(rnd(longint'(speed_mag) * sa, 30) * longint'(step_time), 16);
        yaw = cur_yaw;
      end else begin
        sincos(b, cb, sb);
        nx = cur_x + div_round(longint'(speed_mag) * (sb - sa), w * 16384);
        ny = cur_y + div_round(longint'(speed_mag) * (ca - cb), w * 16384);
        yq = (b + 32'h8000) >> 16;
        yaw = yq[15:0];
      end
      vx = clip(rnd(longint'(held_speed) * ca, 30), -64'sd2147483648, 64'sd2147483647);
      vy = clip(rnd(longint'(held_speed) * sa, 30), -64'sd2147483648, 64'sd2147483647);
      turn_rate_of(longint'(held_speed), held_steer, rate);
      cur_x = clip(nx, -64'sd2147483648, 64'sd2147483647);
      cur_y = clip(ny, -64'sd2147483648, 64'sd2147483647);
      cur_yaw = yaw;
      speed_mag = isqrt(64'(vx * vx) + 64'(vy * vy));
      cur_rate = rate;
      sincos({yaw[15], yaw, 15'h0}, qc, qs);
      qc = clip(rnd(qc, 15), 0, 32767);
      qs = clip(rnd(qs, 15), -32768, 32767);
      e.pos_x = cur_x; e.pos_y = cur_y; e.heading = yaw;
      e.quat_w = qc[14:0]; e.quat_z = qs[15:0];
      e.vel_x = vx[31:0]; e.vel_y = vy[31:0]; e.turn_rate = rate[31:0];
      pose_q.push_back(e);
    endtask

    function void check(pose_t act);
      pose_t e;
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose x=%0d y=%0d", $time, act.pos_x, act.pos_y);
        errors++;
        return;
      end
      e = pose_q.pop_front();
      if (e.pos_x !== act.pos_x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, act.pos_x); errors++;
      end
      if (e.pos_y !== act.pos_y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, act.pos_y); errors++;
      end
      if (e.heading !== act.heading) begin
        $display("%0t: heading expected %0d actual %0d", $time, e.heading, act.heading);
        errors++;
      end
      if (e.quat_w !== act.quat_w) begin
        $display("%0t: quat_w expected %0d actual %0d", $time, e.quat_w, act.quat_w); errors++;
      end
      if (e.quat_z !== act.quat_z) begin
        $display("%0t: quat_z expected %0d actual %0d", $time, e.quat_z, act.quat_z); errors++;
      end
      if (e.vel_x !== act.vel_x) begin
        $display("%0t: vel_x expected %0d actual %0d", $time, e.vel_x, act.vel_x); errors++;
      end
      if (e.vel_y !== act.vel_y) begin
        $display("%0t: vel_y expected %0d actual %0d", $time, e.vel_y, act.vel_y); errors++;
      end
      if (e.turn_rate !== act.turn_rate) begin
        $display("%0t: turn_rate expected %0d actual %0d", $time, e.turn_rate, act.turn_rate);
        errors++;
      end
    endfunction
  endclass

  localparam longint CYCLE_LIMIT = 20000000;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, func;
  logic signed [31:0] cmd_speed_in;
  logic signed [15:0] cmd_steer_in;
  logic out_valid, out_stall;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, turn_rate;
  logic signed [15:0] heading, quat_z;
  logic [14:0] quat_w;

  pose_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  bicycle_model_odometry_step_top DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bicycle_model_odometry_step_top_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{pos_x, pos_y, heading, quat_w, quat_z, vel_x, vel_y, turn_rate});
  end

  task automatic send(input logic f, input logic signed [31:0] spd,
                      input logic signed [15:0] str);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    cmd_speed_in <= spd;
    cmd_steer_in <= str;
    do @(posedge clk); while (in_stall);
    sb.note(f, spd, str);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pose_q.size() != 0) @(negedge clk);
    repeat (900) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic set_all(input logic [31:0] wb, input logic [31:0] st, input logic [31:0] th,
                         input logic [31:0] ix, input logic [31:0] iy);
    write_reg(bmo_pkg::CFG_WHEELBASE, wb);
    write_reg(bmo_pkg::CFG_STEP_TIME, st);
    write_reg(bmo_pkg::CFG_THRESHOLD, th);
    write_reg(bmo_pkg::CFG_INIT_X, ix);
    write_reg(bmo_pkg::CFG_INIT_Y, iy);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    logic signed [31:0] spd;
    logic signed [15:0] str;
    case ($urandom_range(3))
      0: spd = $urandom;
      1: spd = $signed($urandom_range(2097152)) - 32'sd1048576;
      2: spd = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: spd = $signed($urandom_range(655360)) - 32'sd327680;
    endcase
    str = $urandom_range(1) ? 16'($urandom) : 16'($signed($urandom_range(4000)) - 2000);
    if ($urandom_range(99) < 45) send(bmo_pkg::FUNC_TICK, $urandom, $urandom);
    else send(bmo_pkg::FUNC_CMD, spd, str);
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; func = 0; cmd_speed_in = 0; cmd_steer_in = 0; out_stall = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // ticks before the first command, then extreme commands
    send(bmo_pkg::FUNC_TICK, 0, 0);
    settle();
    set_all(65536, 655, 7, 32'h7fff_0000, 32'h8000_0100);
    send(bmo_pkg::FUNC_TICK, 0, 0);
    send(bmo_pkg::FUNC_TICK, 32'hffff_ffff, 16'hffff);
    send(bmo_pkg::FUNC_CMD, 32'sh7fff_ffff, 16'sd0);
    for (int i = 0; i < 4; i++) send(bmo_pkg::FUNC_TICK, 0, 0);
    send(bmo_pkg::FUNC_CMD, 32'sh8000_0000, 16'sh8000);
    for (int i = 0; i < 3; i++) send(bmo_pkg::FUNC_TICK, 0, 0);
    send(bmo_pkg::FUNC_CMD, 32'sd65536, 16'sd16384);
    send(bmo_pkg::FUNC_TICK, 0, 0);
    send(bmo_pkg::FUNC_TICK, 0, 0);
    send(bmo_pkg::FUNC_CMD, 32'sd0, 16'sd32767);
    send(bmo_pkg::FUNC_TICK, 0, 0);
    send(bmo_pkg::FUNC_CMD, 32'sd655360, 16'sd8000);
    for (int i = 0; i < 4; i++) send(bmo_pkg::FUNC_TICK, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: set_all(1, 65535, 0, $urandom, $urandom);
        1: set_all(32'h7fff_ffff, 1, 65535, 32'h8000_0000, 32'h7fff_ffff);
        2: set_all(65536, 655, 7, 0, 0);
        default: set_all($urandom_range(32'h7fff_ffff, 1), $urandom_range(65535, 1),
                         $urandom_range(65535), $urandom, $urandom);
      endcase
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (ph == 2) begin
        hold_cycles = 4000;
        for (int i = 0; i < 6; i++) send(bmo_pkg::FUNC_TICK, 0, 0);
      end
      for (int i = 0; i < 420; i++) random_item();
    end

    settle();
    if (sb.errors == 0 && sb.pose_q.size() == 0)
      $display("bicycle_model_odometry_step_top_tb: clean");
    else
      $display("bicycle_model_odometry_step_top_tb: errors");
    $finish;
  end
endmodule
